@@ design/pcxrle_pkg.sv @@
// ----------------------------------------------------------------------------
// pcxrle_pkg
// Shared types, constants and the microcode program of the PCX RLE decoder.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

  // Register file
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT = 1'b1;
  localparam logic [CFG_W-1:0]     LINE_WIDTH_RST = 13'd320;
  localparam logic [CFG_W-1:0]     LINE_COUNT_RST = 13'd256;

  // Field widths
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned RGB_W  = 24;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned ROW_W  = 12;
  localparam int unsigned COL_W  = 13;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned IN_DW  = 40;
  localparam int unsigned OUT_DW = 56;

  localparam int unsigned PAL_DEPTH = 256;

  localparam logic [7:0]      RUN_MARK = 8'hC0;
  localparam logic [7:0]      RUN_MASK = 8'h3F;
  localparam logic [CH_W-1:0] OPAQUE   = 8'd255;

  // Microcode
  localparam int unsigned PC_W = 4;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LATCH,
    ACT_PAL_WR,
    ACT_SET_FIN,
    ACT_CLR_RUN,
    ACT_MARK,
    ACT_LOAD,
    ACT_SETUP,
    ACT_EMIT,
    ACT_ADVANCE
  } act_e;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_IN,
    WAIT_OUT
  } wait_e;

  typedef enum logic [3:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_FUNC0,
    COND_FINISHED,
    COND_ROW_OVER,
    COND_RUN_ZERO,
    COND_MARK_NEW,
    COND_ZERO_N,
    COND_MORE
  } cond_e;

  typedef struct packed {
    act_e             act;
    wait_e            wt;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    act_e act;
    logic go;
    logic in_ready;
  } ctl_t;

  typedef struct packed {
    logic func0;
    logic finished;
    logic row_over;
    logic run_zero;
    logic mark_new;
    logic zero_n;
    logic more;
    logic in_valid;
    logic out_free;
  } stat_t;

  // Step addresses
  localparam logic [PC_W-1:0] ST_FETCH   = 4'd0;
  localparam logic [PC_W-1:0] ST_T_FUNC  = 4'd1;
  localparam logic [PC_W-1:0] ST_T_FIN   = 4'd2;
  localparam logic [PC_W-1:0] ST_T_ROW   = 4'd3;
  localparam logic [PC_W-1:0] ST_T_RUNZ  = 4'd4;
  localparam logic [PC_W-1:0] ST_T_MARK  = 4'd5;
  localparam logic [PC_W-1:0] ST_LOAD    = 4'd6;
  localparam logic [PC_W-1:0] ST_SETUP   = 4'd7;
  localparam logic [PC_W-1:0] ST_EMIT    = 4'd8;
  localparam logic [PC_W-1:0] ST_ADVANCE = 4'd9;
  localparam logic [PC_W-1:0] ST_PAL_WR  = 4'd10;
  localparam logic [PC_W-1:0] ST_CLR_RUN = 4'd11;
  localparam logic [PC_W-1:0] ST_MARK    = 4'd12;
  localparam logic [PC_W-1:0] ST_SET_FIN = 4'd13;

  function automatic uword_t rom_word(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{act: ACT_NONE, wt: WAIT_NONE, cond: COND_ALWAYS, target: ST_FETCH};
    case (pc)
      ST_FETCH:   w = '{ACT_LATCH,   WAIT_IN,   COND_NONE,     ST_FETCH};
      ST_T_FUNC:  w = '{ACT_NONE,    WAIT_NONE, COND_FUNC0,    ST_PAL_WR};
      ST_T_FIN:   w = '{ACT_NONE,    WAIT_NONE, COND_FINISHED, ST_FETCH};
      ST_T_ROW:   w = '{ACT_NONE,    WAIT_NONE, COND_ROW_OVER, ST_SET_FIN};
      ST_T_RUNZ:  w = '{ACT_NONE,    WAIT_NONE, COND_RUN_ZERO, ST_CLR_RUN};
      ST_T_MARK:  w = '{ACT_NONE,    WAIT_NONE, COND_MARK_NEW, ST_MARK};
      ST_LOAD:    w = '{ACT_LOAD,    WAIT_NONE, COND_NONE,     ST_FETCH};
      ST_SETUP:   w = '{ACT_SETUP,   WAIT_NONE, COND_ZERO_N,   ST_ADVANCE};
      ST_EMIT:    w = '{ACT_EMIT,    WAIT_OUT,  COND_MORE,     ST_EMIT};
      ST_ADVANCE: w = '{ACT_ADVANCE, WAIT_NONE, COND_ALWAYS,   ST_FETCH};
      ST_PAL_WR:  w = '{ACT_PAL_WR,  WAIT_NONE, COND_ALWAYS,   ST_FETCH};
      ST_CLR_RUN: w = '{ACT_CLR_RUN, WAIT_NONE, COND_ALWAYS,   ST_FETCH};
      ST_MARK:    w = '{ACT_MARK,    WAIT_NONE, COND_ALWAYS,   ST_FETCH};
      ST_SET_FIN: w = '{ACT_SET_FIN, WAIT_NONE, COND_ALWAYS,   ST_FETCH};
      default:    w = '{ACT_NONE,    WAIT_NONE, COND_ALWAYS,   ST_FETCH};
    endcase
    return w;
  endfunction

endpackage

@@ design/pcx_rle_palette_decoder.sv @@
// ----------------------------------------------------------------------------
// pcx_rle_palette_decoder
// 8-bit PCX run-length pixel decoder with a 256-entry RGB palette.
// ----------------------------------------------------------------------------
// Items enter on s_axis: tuser = 0 loads palette entry tdata[7:0] with color
// tdata[31:8]; tuser = 1 supplies compressed byte tdata[39:32]. Pixels leave
// on m_axis as palette RGB, alpha 255, row and column; tlast marks the last
// pixel of an input byte and tuser the pixel that completes the image. A
// control store steps one word per cycle except while a step waits on
// s_axis or m_axis, so the cost of an item follows from its program path;
// a pixel byte's cost grows with each pixel emitted and while m_axis stalls.
// The palette needs no clearing after reset; every entry must be written
// before a pixel refers to it. Line width and count must be written through
// cfg_* only while the decoder is idle; the block itself does not enforce
// this. 0 acts as 1 and values above MAX_DIM saturate.
// ----------------------------------------------------------------------------
module pcx_rle_palette_decoder #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pcxrle_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // palette_index[7:0], palette_rgb[31:8], data_byte[39:32]
  input  logic [pcxrle_pkg::IN_DW-1:0]     s_axis_tdata,
  // func
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // red[7:0], green[15:8], blue[23:16], alpha[31:24],
  // pixel_row[43:32], pixel_column[55:44]
  output logic [pcxrle_pkg::OUT_DW-1:0]    m_axis_tdata,
  // run_last
  output logic                             m_axis_tlast,
  // image_done
  output logic                             m_axis_tuser
);
  import pcxrle_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  pcxrle_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  pcxrle_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .ctl_i         (ctl),
    .stat_o        (stat)
  );

endmodule

@@ design/pcxrle_seq.sv @@
// ----------------------------------------------------------------------------
// pcxrle_seq
// Step counter and control store: fetches one control word per cycle, holds
// the step while a wait is unmet, and branches on datapath status.
// ----------------------------------------------------------------------------
module pcxrle_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pcxrle_pkg::stat_t stat_i,
  output pcxrle_pkg::ctl_t  ctl_o
);
  import pcxrle_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;
  logic            go;
  logic            take;

  always_comb begin
    uw = rom_word(pc_q);
    case (uw.wt)
      WAIT_IN:  go = stat_i.in_valid;
      WAIT_OUT: go = stat_i.out_free;
      default:  go = 1'b1;
    endcase
  end

  always_comb begin
    case (uw.cond)
      COND_ALWAYS:   take = 1'b1;
      COND_FUNC0:    take = stat_i.func0;
      COND_FINISHED: take = stat_i.finished;
      COND_ROW_OVER: take = stat_i.row_over;
      COND_RUN_ZERO: take = stat_i.run_zero;
      COND_MARK_NEW: take = stat_i.mark_new;
      COND_ZERO_N:   take = stat_i.zero_n;
      COND_MORE:     take = stat_i.more;
      default:       take = 1'b0;
    endcase
  end

  always_comb begin
    if (!go) begin
      pc_d = pc_q;
    end else if (take) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  always_comb begin
    ctl_o.act      = uw.act;
    ctl_o.go       = go;
    ctl_o.in_ready = (uw.wt == WAIT_IN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

@@ design/pcxrle_dp.sv @@
// ----------------------------------------------------------------------------
// pcxrle_dp
// Datapath: size registers, input latch, run and position state, palette
// memory and the output register.
// ----------------------------------------------------------------------------
module pcxrle_dp #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pcxrle_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pcxrle_pkg::IN_DW-1:0]  s_axis_tdata,
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pcxrle_pkg::OUT_DW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,
  output logic                          m_axis_tuser,
  input  pcxrle_pkg::ctl_t              ctl_i,
  output pcxrle_pkg::stat_t             stat_o
);
  import pcxrle_pkg::*;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      r = CFG_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [CFG_W-1:0] line_width_q, line_count_q;

  logic             func_q;
  logic [IDX_W-1:0] pal_idx_q;
  logic [RGB_W-1:0] pal_rgb_q;
  logic [7:0]       byte_q;

  logic             run_pending_q;
  logic [CNT_W-1:0] run_count_q;
  logic [COL_W-1:0] cur_col_q;
  logic [ROW_W-1:0] cur_row_q;
  logic             finished_q;

  logic [CNT_W-1:0] cnt_q;
  logic [IDX_W-1:0] idx_q;
  logic [CNT_W-1:0] n_left_q;
  logic             ends_q, lastrow_q;
  logic [COL_W-1:0] pix_col_q;

  logic [RGB_W-1:0] pal_mem [PAL_DEPTH];
  logic [RGB_W-1:0] rd_q;

  logic             out_valid_q;
  logic [RGB_W-1:0] out_rgb_q;
  logic [ROW_W-1:0] out_row_q;
  logic [ROW_W-1:0] out_col_q;
  logic             out_last_q, out_done_q;

  logic [COL_W-1:0] room;
  logic [CNT_W-1:0] n_c;
  logic [COL_W:0]   col_sum;
  logic             ends_c, lastrow_c, row_over;
  logic             marker;
  logic             do_act;
  logic             emit_go;

  // Pixels that fit on the current row, and whether this byte closes it
  always_comb begin
    room      = (cur_col_q < line_width_q) ? (line_width_q - cur_col_q) : '0;
    n_c       = (COL_W'(cnt_q) < room) ? cnt_q : room[CNT_W-1:0];
    col_sum   = {1'b0, cur_col_q} + (COL_W+1)'(cnt_q);
    ends_c    = col_sum >= {1'b0, line_width_q};
    lastrow_c = ({1'b0, cur_row_q} + CFG_W'(1)) >= line_count_q;
    row_over  = {1'b0, cur_row_q} >= line_count_q;
    marker    = (byte_q & RUN_MARK) == RUN_MARK;
    do_act    = ctl_i.go;
    emit_go   = do_act && (ctl_i.act == ACT_EMIT);
  end

  always_comb begin
    stat_o.func0    = !func_q;
    stat_o.finished = finished_q;
    stat_o.row_over = row_over;
    stat_o.run_zero = run_pending_q && (run_count_q == '0);
    stat_o.mark_new = !run_pending_q && marker;
    stat_o.zero_n   = (n_c == '0);
    stat_o.more     = (n_left_q != CNT_W'(1));
    stat_o.in_valid = s_axis_tvalid;
    stat_o.out_free = !out_valid_q || m_axis_tready;
  end

  assign s_axis_tready = ctl_i.in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RST;
      line_count_q <= LINE_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LINE_WIDTH: line_width_q <= clamp_dim(cfg_data_i);
        REG_LINE_COUNT: line_count_q <= clamp_dim(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Item latch and working registers of the current byte
  always_ff @(posedge clk_i) begin
    if (do_act && (ctl_i.act == ACT_LATCH)) begin
      func_q    <= s_axis_tuser;
      pal_idx_q <= s_axis_tdata[IDX_W-1:0];
      pal_rgb_q <= s_axis_tdata[IDX_W+RGB_W-1:IDX_W];
      byte_q    <= s_axis_tdata[IN_DW-1:IDX_W+RGB_W];
    end
    if (do_act && (ctl_i.act == ACT_LOAD)) begin
      cnt_q <= run_pending_q ? run_count_q : CNT_W'(1);
      idx_q <= byte_q;
    end
    if (do_act && (ctl_i.act == ACT_SETUP)) begin
      ends_q    <= ends_c;
      lastrow_q <= lastrow_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_pending_q <= 1'b0;
      run_count_q   <= '0;
      cur_col_q     <= '0;
      cur_row_q     <= '0;
      finished_q    <= 1'b0;
      n_left_q      <= '0;
      pix_col_q     <= '0;
    end else if (do_act) begin
      case (ctl_i.act)
        ACT_SET_FIN: finished_q <= 1'b1;
        ACT_CLR_RUN: begin
          run_pending_q <= 1'b0;
          run_count_q   <= '0;
        end
        ACT_MARK: begin
          run_pending_q <= 1'b1;
          run_count_q   <= byte_q[CNT_W-1:0] & RUN_MASK[CNT_W-1:0];
        end
        ACT_LOAD: begin
          run_pending_q <= 1'b0;
          run_count_q   <= '0;
        end
        ACT_SETUP: begin
          n_left_q  <= n_c;
          pix_col_q <= cur_col_q;
        end
        ACT_EMIT: begin
          n_left_q  <= n_left_q - CNT_W'(1);
          pix_col_q <= pix_col_q + COL_W'(1);
        end
        ACT_ADVANCE: begin
          if (ends_q) begin
            cur_col_q <= '0;
            if (lastrow_q) begin
              finished_q <= 1'b1;
            end else begin
              cur_row_q <= cur_row_q + ROW_W'(1);
            end
          end else begin
            cur_col_q <= col_sum[COL_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Palette store; the read issued in setup is registered for the emit step
  always_ff @(posedge clk_i) begin
    if (do_act && (ctl_i.act == ACT_PAL_WR)) begin
      pal_mem[pal_idx_q] <= pal_rgb_q;
    end
    if (do_act && (ctl_i.act == ACT_SETUP)) begin
      rd_q <= pal_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_go) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      out_rgb_q  <= rd_q;
      out_row_q  <= cur_row_q;
      out_col_q  <= pix_col_q[ROW_W-1:0];
      out_last_q <= (n_left_q == CNT_W'(1));
      out_done_q <= (n_left_q == CNT_W'(1)) && ends_q && lastrow_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_col_q, out_row_q, OPAQUE,
                          out_rgb_q[CH_W-1:0],
                          out_rgb_q[2*CH_W-1:CH_W],
                          out_rgb_q[3*CH_W-1:2*CH_W]};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_done_q;

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!out_done_q || out_last_q))
    else $error("image end flagged on a pixel that is not the last of its byte");

  a_emit_has_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |-> (n_left_q != '0))
    else $error("pixel emitted with no pixels left");

  a_emit_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |-> (pix_col_q < line_width_q))
    else $error("pixel column beyond line width");

  a_out_not_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |-> (!out_valid_q || m_axis_tready))
    else $error("output register overwritten while held");

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: PCX RLE palette decoder testbench
// Loads palette entries and streams compressed bytes through the decoder.
// An in-bench decoder model tracks the palette, the pending run and the
// pixel position, queues the expected pixels for each accepted item, and a
// checker compares every pixel that leaves the block. Both stream sides idle
// at random, and the line size is changed between phases while the decoder
// is idle.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcxrle_pkg::*;

  localparam int SETTLE_CYCLES = 20;
  localparam int DIM_MAX       = 4096;
  localparam int RAND_PHASES   = 5;
  localparam int PHASE_ITEMS   = 20;
  localparam int DRAIN_LIMIT   = 200000;

  localparam logic [RAND_PHASES-1:0][CFG_W-1:0] PHASE_WIDTH =
    {13'd3, 13'd4096, 13'd40, 13'd1, 13'd7};
  localparam logic [RAND_PHASES-1:0][CFG_W-1:0] PHASE_ROWS =
    {13'd2500, 13'd4096, 13'd3000, 13'd4096, 13'd4000};

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [11:0] row;
    logic [11:0] col;
    logic        run_last;
    logic        image_done;
  } pixel_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [IN_DW-1:0]     s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_DW-1:0]    m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 m_axis_tuser;

  // Decoder model state
  logic [RGB_W-1:0] color_tab [PAL_DEPTH];
  bit               pal_ok [PAL_DEPTH];
  bit               run_pend;
  int               run_len;
  int               col_pos;
  int               row_pos;
  bit               img_fin;
  int               width_now;
  int               rows_now;

  pixel_t pixq[$];
  int     err_cnt;
  int     pix_cnt;
  int     item_cnt;
  bit     calm;
  int     stall_left;

  pcx_rle_palette_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100ms;
    $display("tb: FAIL");
    $finish;
  end

  function automatic int clamp_dim(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_MAX) return DIM_MAX;
    return int'(v);
  endfunction

  function automatic int idle_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Palette indexes are only drawn from entries already loaded.
  function automatic logic [7:0] pick_lit();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 8'hBF)); while (!pal_ok[v]);
    return v;
  endfunction

  function automatic logic [7:0] pick_any();
    logic [7:0] v;
    do v = 8'($urandom); while (!pal_ok[v]);
    return v;
  endfunction

  // Queue the pixels of one byte at the current position, then advance.
  function automatic void paint(input logic [7:0] idx, input int cnt);
    int     room;
    int     n;
    bit     ends_row;
    bit     last_row;
    pixel_t p;
    room     = (col_pos < width_now) ? width_now - col_pos : 0;
    n        = (cnt < room) ? cnt : room;
    ends_row = (col_pos + cnt) >= width_now;
    last_row = (row_pos + 1) >= rows_now;
    for (int k = 0; k < n; k++) begin
      p.red        = color_tab[idx][23:16];
      p.green      = color_tab[idx][15:8];
      p.blue       = color_tab[idx][7:0];
      p.alpha      = OPAQUE;
      p.row        = 12'(row_pos);
      p.col        = 12'(col_pos + k);
      p.run_last   = (k == n - 1);
      p.image_done = p.run_last && ends_row && last_row && (col_pos + k + 1 == width_now);
      pixq.push_back(p);
    end
    if (ends_row) begin
      col_pos = 0;
      if (last_row) img_fin = 1'b1;
      else row_pos = row_pos + 1;
    end else begin
      col_pos = (col_pos + cnt) & 32'h1FFF;
    end
  endfunction

  function automatic void decode_item(input bit func, input logic [7:0] idx,
                                      input logic [23:0] rgb, input logic [7:0] dbyte);
    int cnt;
    if (!func) begin
      color_tab[idx] = rgb;
      pal_ok[idx]    = 1'b1;
      return;
    end
    if (img_fin) return;
    if (row_pos >= rows_now) begin
      img_fin = 1'b1;
      return;
    end
    if (run_pend) begin
      cnt      = run_len;
      run_pend = 1'b0;
      run_len  = 0;
      if (cnt != 0) paint(dbyte, cnt);
      return;
    end
    if ((dbyte & RUN_MARK) == RUN_MARK) begin
      run_pend = 1'b1;
      run_len  = int'(dbyte & RUN_MASK);
      return;
    end
    paint(dbyte, 1);
  endfunction

  // Hold valid across back-to-back items; drop it only for a gap.
  task automatic send_item(input bit func, input logic [7:0] idx,
                           input logic [23:0] rgb, input logic [7:0] dbyte);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {dbyte, rgb, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    item_cnt++;
    decode_item(func, idx, rgb, dbyte);
  endtask

  task automatic send_pal(input logic [7:0] idx, input logic [23:0] rgb);
    send_item(1'b0, idx, rgb, 8'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(1'b1, 8'($urandom), 24'($urandom), b);
  endtask

  // Drain all pixels and let the last item finish before touching a register.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (pixq.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_LINE_WIDTH) width_now = clamp_dim(value);
    else rows_now = clamp_dim(value);
  endtask

  always @(posedge clk_i) begin : pixel_check
    pixel_t got;
    pixel_t want;
    int     roll;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
             m_axis_tdata[31:24], m_axis_tdata[43:32], m_axis_tdata[55:44],
             m_axis_tlast, m_axis_tuser};
      if (pixq.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected pixel row %0d col %0d rgba %h", $time,
                 got.row, got.col, {got.red, got.green, got.blue, got.alpha});
      end else begin
        want = pixq.pop_front();
        pix_cnt++;
        if (got !== want) begin
          err_cnt++;
          $display("%0t: pixel mismatch: expected rgba %h row %0d col %0d last %b done %b",
                   $time, {want.red, want.green, want.blue, want.alpha}, want.row,
                   want.col, want.run_last, want.image_done);
          $display("%0t:                 actual   rgba %h row %0d col %0d last %b done %b",
                   $time, {got.red, got.green, got.blue, got.alpha}, got.row,
                   got.col, got.run_last, got.image_done);
        end
      end
    end
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        m_axis_tready <= 1'b1;
      end else if (roll < 94) begin
        stall_left    <= $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        stall_left    <= $urandom_range(9, 39);
        m_axis_tready <= 1'b0;
      end
    end
  end

  task automatic test_palette_load();
    send_pal(8'h00, 24'h000000);
    send_pal(8'hFF, 24'hFFFFFF);
    send_pal(8'hBF, 24'hA5C35A);
    send_pal(8'hC0, 24'h5A3CA5);
    send_pal(8'h3F, 24'h0F00F0);
    repeat (12) send_pal(8'($urandom), 24'($urandom));
  endtask

  task automatic test_pixel_codes();
    calm = 1'b1;
    send_byte(8'h00);
    send_byte(8'hBF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    // zero count: marker and index yield nothing
    send_byte(8'hC0);
    send_byte(8'h00);
    // palette write lands between marker and index
    send_byte(8'hC1);
    send_pal(8'h3F, 24'hF0F0F0);
    send_byte(8'h3F);
    send_byte(8'hC5);
    send_byte(8'hC0);
    calm = 1'b0;
  endtask

  task automatic test_line_end();
    // column is already past the new width: next pixel is dropped
    write_reg(REG_LINE_WIDTH, 13'd3);
    send_byte(pick_lit());
    send_byte(pick_lit());
    send_byte(8'hC8);
    send_byte(pick_any());
    write_reg(REG_LINE_WIDTH, 13'd0);
    repeat (3) send_byte(pick_lit());
    send_byte(8'hC3);
    send_byte(pick_any());
  endtask

  task automatic test_wide_row();
    write_reg(REG_LINE_WIDTH, 13'h1FFF);
    write_reg(REG_LINE_COUNT, 13'h1FFF);
    do begin
      send_byte(8'hFF);
      send_byte(pick_any());
    end while (col_pos != 0);
  endtask

  task automatic test_random_stream();
    int roll;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      calm = (ph == 0);
      write_reg(REG_LINE_WIDTH, PHASE_WIDTH[ph]);
      write_reg(REG_LINE_COUNT, PHASE_ROWS[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 12) send_pal(8'($urandom), 24'($urandom));
        else if (run_pend) send_byte(pick_any());
        else if (roll < 50) send_byte(pick_lit());
        else if (roll < 60) send_byte(RUN_MARK | 8'($urandom_range(0, 3)));
        else send_byte(RUN_MARK | 8'($urandom_range(0, 63)));
      end
    end
    calm = 1'b0;
  endtask

  task automatic test_image_end();
    write_reg(REG_LINE_WIDTH, 13'd6);
    while (col_pos != 0) send_byte(pick_lit());
    write_reg(REG_LINE_COUNT, 13'(row_pos + 1));
    send_byte(8'hFF);
    send_byte(pick_any());
    // image is complete: data bytes are ignored from here on
    send_byte(pick_lit());
    send_byte(8'hC4);
    send_pal(8'h00, 24'h00FF00);
    send_byte(8'hFF);
    write_reg(REG_LINE_COUNT, 13'd0);
    send_byte(8'h00);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_LINE_WIDTH;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    run_pend      = 1'b0;
    run_len       = 0;
    col_pos       = 0;
    row_pos       = 0;
    img_fin       = 1'b0;
    width_now     = int'(LINE_WIDTH_RST);
    rows_now      = int'(LINE_COUNT_RST);
    err_cnt       = 0;
    pix_cnt       = 0;
    item_cnt      = 0;
    calm          = 1'b0;
    stall_left    = 0;
    for (int i = 0; i < PAL_DEPTH; i++) begin
      color_tab[i] = '0;
      pal_ok[i]    = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_palette_load();
    test_pixel_codes();
    test_line_end();
    test_wide_row();
    test_random_stream();
    test_image_end();

    s_axis_tvalid <= 1'b0;
    for (int t = 0; t < DRAIN_LIMIT && pixq.size() != 0; t++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pixq.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d expected pixels never arrived", $time, pixq.size());
    end

    $display("summary: %0d items sent, %0d pixels checked over %0d rows", item_cnt,
             pix_cnt, row_pos + 1);
    $display("summary: widths 1 to 4096, runs of 0 to 63, line-end drops, image completion");
    if (err_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
